### rtl/core/affine_transform_matrix_engine_defines.svh
// Assertion macros for the affine transform matrix engine checkers.
`ifndef AFFINE_TRANSFORM_MATRIX_ENGINE_DEFINES_SVH
`define AFFINE_TRANSFORM_MATRIX_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ATME_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atme: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define ATME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atme: next-cycle check failed");

`endif

### rtl/core/atme_pkg.sv
// Shared types, opcodes and saturation helper for the matrix engine.
package atme_pkg;

  localparam int DATA_W = 32;
  localparam int COEF_W = 33;
  localparam int ACC_W  = 64;

  localparam logic [3:0] OP_IDENT = 4'd0;
  localparam logic [3:0] OP_WRITE = 4'd1;
  localparam logic [3:0] OP_ROTX  = 4'd2;
  localparam logic [3:0] OP_ROTY  = 4'd3;
  localparam logic [3:0] OP_ROTZ  = 4'd4;
  localparam logic [3:0] OP_TRANS = 4'd5;
  localparam logic [3:0] OP_SCALE = 4'd6;
  localparam logic [3:0] OP_INV   = 4'd7;
  localparam logic [3:0] OP_XFORM = 4'd8;
  localparam logic [3:0] OP_READ  = 4'd9;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    logic load;
    logic accum;
    logic neg;
  } lane_ctl_t;

  localparam acc_t SAT_MAX = acc_t'(64'sh0000_0000_7FFF_FFFF);
  localparam acc_t SAT_MIN = acc_t'(-64'sh0000_0000_8000_0000);

  function automatic q_t sat32(acc_t v);
    q_t r;
    if (v > SAT_MAX) begin
      r = q_t'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r = q_t'(SAT_MIN);
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/atme_lane.sv
// One multiply-accumulate lane: registered product, accumulator, saturation.
module atme_lane
  import atme_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  lane_ctl_t ctl,
  input  q_t        addend,
  input  coef_t     coef,
  input  q_t        ent_v,
  output q_t        result
);

  logic signed [COEF_W+DATA_W-1:0] prod_r;
  acc_t acc_r;
  acc_t acc_nxt;
  acc_t prod_sh;

  // arithmetic shift rounds toward minus infinity
  assign prod_sh = acc_t'(prod_r >>> FRAC_BITS);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.load) begin
      acc_nxt = acc_t'(addend);
    end else if (ctl.accum) begin
      acc_nxt = acc_r + prod_sh;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= coef * ent_v;
    acc_r  <= acc_nxt;
  end

  assign result = sat32(ctl.neg ? -acc_r : acc_r);

endmodule

### rtl/core/affine_transform_matrix_engine.sv
// Top level: 4x4 Q16.16 row-vector transform matrix with four MAC lanes.
//
// Usage: present an item on in_opcode, in_entry_index and in_operand_a..c
// with start high; it is taken at a rising edge where busy is low.
// Load identity and write entry update the matrix in that same edge and
// leave busy low, so they can be issued every cycle. Read entry puts the
// entry on out_x (out_y..out_w zero) with out_valid in the next cycle and
// also leaves busy low.
// Arithmetic opcodes run through four lanes, each one 33x32 multiplier and
// an accumulator; a pass feeds up to three product terms through each
// lane's multiplier in turn: transform and quick inverse take one pass,
// rotations two, translate and scale three. A transform raises out_valid
// for one cycle in the same cycle that busy falls.
// A result is shown for exactly one cycle and must be taken then.
// Synchronous active-low reset clears the matrix to zero, drops busy and
// out_valid.
module affine_transform_matrix_engine
  import atme_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_opcode,
  input  logic [3:0]  in_entry_index,
  input  q_t          in_operand_a,
  input  q_t          in_operand_b,
  input  q_t          in_operand_c,
  output logic        out_valid,
  output q_t          out_x,
  output q_t          out_y,
  output q_t          out_z,
  output q_t          out_w
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [2:0] STEP_ACC = 3'd3;
  localparam logic [2:0] STEP_WB  = 3'd4;

  localparam q_t ONE_Q = 32'sd1 <<< FRAC_BITS;

  logic       state_r, state_nxt;
  logic [1:0] pass_r, pass_nxt;
  logic [2:0] step_r, step_nxt;
  logic [3:0] op_r;
  q_t         a_r, b_r, c_r;
  q_t         snap_r [16];
  q_t         m_r    [16];
  q_t         m_nxt  [16];

  logic       out_valid_r, out_valid_nxt;
  q_t         out_x_r, out_y_r, out_z_r, out_w_r;
  q_t         out_x_nxt, out_y_nxt, out_z_nxt, out_w_nxt;

  logic       accept;
  logic       run;
  logic [1:0] last_pass;
  logic [1:0] rot_p, rot_q;
  coef_t      b_ext, b_neg, rot_sp, rot_sq;
  q_t         opnd_p, opnd_k;
  logic [1:0] k;

  lane_ctl_t  lane_ctl;
  coef_t      coef   [4];
  q_t         ent_v  [4];
  q_t         addend [4];
  q_t         res    [4];

  assign accept = start && !busy;
  assign run    = (state_r == ST_RUN);
  assign busy   = run;
  assign k      = step_r[1:0];

  assign lane_ctl.load  = run && (step_r == 3'd0);
  assign lane_ctl.accum = run && (step_r != 3'd0) && (step_r <= STEP_ACC);
  assign lane_ctl.neg   = (op_r == OP_INV);

  assign b_ext = coef_t'(b_r);
  assign b_neg = -b_ext;

  always_comb begin
    case (op_r)
      OP_ROTX: begin
        rot_p  = 2'd1;
        rot_q  = 2'd2;
        rot_sp = b_neg;
        rot_sq = b_ext;
      end
      OP_ROTY: begin
        rot_p  = 2'd0;
        rot_q  = 2'd2;
        rot_sp = b_ext;
        rot_sq = b_neg;
      end
      default: begin
        rot_p  = 2'd0;
        rot_q  = 2'd1;
        rot_sp = b_neg;
        rot_sq = b_ext;
      end
    endcase
  end

  always_comb begin
    case (op_r) inside
      OP_ROTX, OP_ROTY, OP_ROTZ: last_pass = 2'd1;
      OP_TRANS, OP_SCALE:        last_pass = 2'd2;
      default:                   last_pass = 2'd0;
    endcase
  end

  always_comb begin
    case (pass_r)
      2'd0:    opnd_p = a_r;
      2'd1:    opnd_p = b_r;
      default: opnd_p = c_r;
    endcase
    case (k)
      2'd0:    opnd_k = a_r;
      2'd1:    opnd_k = b_r;
      default: opnd_k = c_r;
    endcase
  end

  // per-lane operand select: lane = row for rotate/translate/scale,
  // lane = column for transform, inverse lane i reads row i into column i
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      coef[i]   = '0;
      ent_v[i]  = '0;
      addend[i] = '0;
      case (op_r) inside
        OP_ROTX, OP_ROTY, OP_ROTZ: begin
          if (step_r == 3'd0) begin
            coef[i]  = (pass_r == 2'd0) ? coef_t'(a_r) : rot_sq;
            ent_v[i] = snap_r[{2'(i), rot_p}];
          end else if (step_r == 3'd1) begin
            coef[i]  = (pass_r == 2'd0) ? rot_sp : coef_t'(a_r);
            ent_v[i] = snap_r[{2'(i), rot_q}];
          end
        end
        OP_TRANS: begin
          if (step_r == 3'd0) begin
            coef[i]  = coef_t'(opnd_p);
            ent_v[i] = snap_r[{2'(i), 2'd3}];
          end
          addend[i] = snap_r[{2'(i), pass_r}];
        end
        OP_SCALE: begin
          if (step_r == 3'd0) begin
            coef[i]  = coef_t'(opnd_p);
            ent_v[i] = snap_r[{2'(i), pass_r}];
          end
        end
        OP_INV: begin
          if (i < 3 && step_r < 3'd3) begin
            coef[i]  = coef_t'(snap_r[{2'd3, k}]);
            ent_v[i] = snap_r[{2'(i), k}];
          end
        end
        OP_XFORM: begin
          if (step_r < 3'd3) begin
            coef[i]  = coef_t'(opnd_k);
            ent_v[i] = snap_r[{k, 2'(i)}];
          end
          addend[i] = snap_r[{2'd3, 2'(i)}];
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    atme_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .ctl    (lane_ctl),
      .addend (addend[g]),
      .coef   (coef[g]),
      .ent_v  (ent_v[g]),
      .result (res[g])
    );
  end

  // next state: idle ops and lane write-back update the matrix or result beat
  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    step_nxt      = step_r;
    m_nxt         = m_r;
    out_valid_nxt = 1'b0;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_w_nxt     = out_w_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode) inside
            OP_IDENT: begin
              for (int i = 0; i < 16; i++) begin
                m_nxt[i] = '0;
              end
              for (int r = 0; r < 4; r++) begin
                m_nxt[{2'(r), 2'(r)}] = ONE_Q;
              end
            end
            OP_WRITE: m_nxt[in_entry_index] = in_operand_a;
            OP_READ: begin
              out_valid_nxt = 1'b1;
              out_x_nxt     = m_r[in_entry_index];
              out_y_nxt     = '0;
              out_z_nxt     = '0;
              out_w_nxt     = '0;
            end
            OP_ROTX, OP_ROTY, OP_ROTZ, OP_TRANS, OP_SCALE, OP_INV, OP_XFORM: begin
              state_nxt = ST_RUN;
              pass_nxt  = 2'd0;
              step_nxt  = 3'd0;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (step_r != STEP_WB) begin
          step_nxt = step_r + 3'd1;
        end else begin
          step_nxt = 3'd0;
          if (pass_r == last_pass) begin
            state_nxt = ST_IDLE;
          end else begin
            pass_nxt = pass_r + 2'd1;
          end
          case (op_r) inside
            OP_ROTX, OP_ROTY, OP_ROTZ: begin
              for (int i = 0; i < 4; i++) begin
                m_nxt[{2'(i), (pass_r == 2'd0) ? rot_p : rot_q}] = res[i];
              end
            end
            OP_TRANS, OP_SCALE: begin
              for (int i = 0; i < 4; i++) begin
                m_nxt[{2'(i), pass_r}] = res[i];
              end
            end
            OP_INV: begin
              for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                  m_nxt[{2'(r), 2'(c)}] = snap_r[{2'(c), 2'(r)}];
                end
                m_nxt[{2'(r), 2'd3}] = '0;
                m_nxt[{2'd3, 2'(r)}] = res[r];
              end
              m_nxt[{2'd3, 2'd3}] = ONE_Q;
            end
            OP_XFORM: begin
              out_valid_nxt = 1'b1;
              out_x_nxt     = res[0];
              out_y_nxt     = res[1];
              out_z_nxt     = res[2];
              out_w_nxt     = res[3];
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= 2'd0;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        m_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      m_r         <= m_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_z_r <= out_z_nxt;
    out_w_r <= out_w_nxt;
    if (accept) begin
      op_r   <= in_opcode;
      a_r    <= in_operand_a;
      b_r    <= in_operand_b;
      c_r    <= in_operand_c;
      snap_r <= m_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;
  assign out_w     = out_w_r;

endmodule

### rtl/core/atme_chk.sv
// Port-level checker for the matrix engine, bound to the top level.
`include "affine_transform_matrix_engine_defines.svh"

module atme_chk
  import atme_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [3:0] in_opcode,
  input logic       out_valid,
  input q_t         out_y,
  input q_t         out_z,
  input q_t         out_w
);

  `ATME_ASSERT_SAME(a_no_stray_result, out_valid, $past(start && !busy) || $past(busy))
  `ATME_ASSERT_SAME(a_busy_from_start, $rose(busy), $past(start && !busy))
  `ATME_ASSERT_NEXT(a_read_one_cycle, start && !busy && in_opcode == OP_READ, out_valid && !busy && out_y == 0 && out_z == 0 && out_w == 0)
  `ATME_ASSERT_NEXT(a_xform_goes_busy, start && !busy && in_opcode == OP_XFORM, busy && !out_valid)

endmodule

bind affine_transform_matrix_engine atme_chk u_atme_chk (.*);
